[rtl/core/csgc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// csgc_pkg
// Shared types and constants of the column stripe gain correction unit.
// ----------------------------------------------------------------------------
package csgc_pkg;

   localparam int PixWidth   = 14;
   localparam int GainWidth  = 17;
   localparam int NumPix     = 8;
   localparam int NumLanes   = 6;      // pixels 2..7 are corrected
   localparam int FirstLane  = 2;
   localparam int CsrIdxWidth = 3;
   localparam int CsrDataWidth = GainWidth;

   localparam int GainFracBits = 16;   // 1.16 gain, divide by 65536
   localparam int DarkMargin   = 64;

   localparam logic [PixWidth-1:0] BlackReset = PixWidth'(2048);
   localparam logic [PixWidth-1:0] WhiteReset = PixWidth'(16383);
   localparam logic [PixWidth-1:0] PeakReset  = PixWidth'((16383 * 2) / 3);

   // floor(x / 3) = (x * ThirdMul) >> ThirdShift for x below 2^16
   localparam int ThirdShift = 17;
   localparam int ThirdMul   = ((1 << ThirdShift) + 2) / 3;

   typedef logic [PixWidth-1:0]  pix_type;
   typedef logic [GainWidth-1:0] gain_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_GAIN_COL2     = 3'd0,
      CSR_GAIN_COL3     = 3'd1,
      CSR_GAIN_COL4     = 3'd2,
      CSR_GAIN_COL5     = 3'd3,
      CSR_GAIN_COL6     = 3'd4,
      CSR_GAIN_COL7     = 3'd5,
      CSR_BLACK_LEVEL   = 3'd6,
      CSR_NOMINAL_WHITE = 3'd7
   } csr_idx_type;

   typedef enum logic {
      MODE_SCAN    = 1'b0,
      MODE_CORRECT = 1'b1
   } mode_type;

   typedef struct packed {
      logic    mode;
      logic    frame_start;
      pix_type in_pix0;
      pix_type in_pix1;
      pix_type in_pix2;
      pix_type in_pix3;
      pix_type in_pix4;
      pix_type in_pix5;
      pix_type in_pix6;
      pix_type in_pix7;
   } req_type;

   typedef struct packed {
      pix_type out_pix0;
      pix_type out_pix1;
      pix_type out_pix2;
      pix_type out_pix3;
      pix_type out_pix4;
      pix_type out_pix5;
      pix_type out_pix6;
      pix_type out_pix7;
   } rsp_type;

   // control shared by all correction lanes
   typedef struct packed {
      logic    load;     // correct transfer, capture this lane's pixel
      logic    bright;   // pixel 0 above black plus margin
      pix_type black;
      pix_type peak;
   } lane_ctl_type;

endpackage : csgc_pkg
`default_nettype wire

[rtl/core/csgc_peak.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// csgc_peak
// Frame peak tracker: max of base and the eight pixels of a scan block.
// ----------------------------------------------------------------------------
module csgc_peak
   import csgc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    scan,
   input  wire logic    frame_start,
   input  wire pix_type nominal_white,
   input  wire pix_type pix [NumPix],
   output pix_type      peak
);

   pix_type                     peak_ff;
   pix_type                     peak_in;
   logic [PixWidth:0]           white_x2;
   logic [PixWidth+ThirdShift:0] third_prod;
   pix_type                     start_peak;
   pix_type                     base;

   assign white_x2   = {nominal_white, 1'b0};
   assign third_prod = (PixWidth+ThirdShift+1)'(white_x2) *
                       (PixWidth+ThirdShift+1)'(ThirdMul);
   assign start_peak = third_prod[ThirdShift +: PixWidth];
   assign base       = frame_start ? start_peak : peak_ff;

   always_comb begin
      peak_in = base;
      for (int k = 0; k < NumPix; k++) begin
         if (pix[k] > peak_in) begin
            peak_in = pix[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff <= PeakReset;
      end else if (scan) begin
         peak_ff <= peak_in;
      end
   end

   assign peak = peak_ff;

endmodule : csgc_peak
`default_nettype wire

[rtl/core/csgc_lane.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// csgc_lane
// One correction lane: gain multiply about black, then round toward zero,
// re-add black and clamp to the peak, or pass the pixel through unchanged.
// ----------------------------------------------------------------------------
module csgc_lane
   import csgc_pkg::*;
(
   input  wire logic         clock,
   input  wire lane_ctl_type ctl,
   input  wire pix_type      pix,
   input  wire gain_type     gain,
   output pix_type           result
);

   localparam int DiffW = PixWidth + 1;
   localparam int ProdW = DiffW + GainWidth + 1;
   localparam int QuotW = ProdW - GainFracBits;
   localparam int SumW  = PixWidth + 4;

   // stage 1: product
   logic signed [DiffW-1:0] diff;
   logic signed [ProdW-1:0] diff_x;
   logic signed [ProdW-1:0] gain_x;
   logic signed [ProdW-1:0] prod_ff;
   logic                    apply_ff;
   logic                    apply_in;
   pix_type                 pix_ff;
   pix_type                 peak_ff;

   // stage 2: finish
   logic signed [ProdW-1:0] adj;
   logic signed [QuotW-1:0] quot;
   logic signed [SumW-1:0]  val;
   logic signed [SumW-1:0]  peak_x;

   assign diff   = $signed({1'b0, pix}) - $signed({1'b0, ctl.black});
   assign diff_x = {{(ProdW-DiffW){diff[DiffW-1]}}, diff};
   assign gain_x = {{(ProdW-GainWidth){1'b0}}, gain};
   assign apply_in = (gain != '0) && (pix != '0) && (pix < ctl.peak) && ctl.bright;

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         prod_ff  <= diff_x * gain_x;
         apply_ff <= apply_in;
         pix_ff   <= pix;
         peak_ff  <= ctl.peak;
      end
   end

   // bias negative products so the shift truncates toward zero
   assign adj    = prod_ff + (prod_ff[ProdW-1] ?
                   ProdW'((1 << GainFracBits) - 1) : ProdW'(0));
   assign quot   = adj[ProdW-1:GainFracBits];
   assign val    = {{(SumW-QuotW){quot[QuotW-1]}}, quot} +
                   $signed({{(SumW-PixWidth){1'b0}}, ctl.black});
   assign peak_x = $signed({{(SumW-PixWidth){1'b0}}, peak_ff});

   always_comb begin
      priority if (!apply_ff) begin
         result = pix_ff;
      end else if (val > peak_x) begin
         result = peak_ff;
      end else begin
         result = val[PixWidth-1:0];
      end
   end

endmodule : csgc_lane
`default_nettype wire

[rtl/core/column_stripe_gain_correction_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// column_stripe_gain_correction_unit
// Per-column gain correction of eight-pixel raw blocks with peak tracking.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one block of eight 14-bit pixels per transfer (valid/stall).
//            Scan blocks (mode 0) update the frame peak at the transfer and
//            produce no result; correct blocks (mode 1) produce one result.
//   rsp_*  : corrected block, pixels 0 and 1 unchanged (valid/stall).
//   csr_*  : register writes, index 0..5 gains of pixels 2..7, 6 black
//            level, 7 nominal white. csr_ready is always high; write only
//            while no block is in flight.
// Path: a correct block is registered in the multiply stage of the lanes,
//   then in the output register, from which rsp shows it.
// Throughput: one block per cycle while rsp_stall is low; set by the single
//   multiply stage of the six lanes, which all run in parallel.
// Reset: gains 0, black 2048, white 16383, peak 10922, pipeline empty.
// Stall: rsp_stall holds the output register; one more correct block is
//   still taken into the multiply stage, after which req_stall rises.
//   Scan blocks are taken whenever req_stall is low.
// ----------------------------------------------------------------------------
module column_stripe_gain_correction_unit
   import csgc_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   // block input
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire req_type                 req_data,
   // result output
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output rsp_type                      rsp_data,
   // register writes
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [CsrIdxWidth-1:0]  csr_index,
   input  wire logic [CsrDataWidth-1:0] csr_wdata
);

   // configuration
   gain_type     gain_ff [NumLanes];
   pix_type      black_ff;
   pix_type      white_ff;

   // handshake and pipeline control
   logic         req_xfer;
   logic         scan_xfer;
   logic         corr_xfer;
   logic         out_adv;       // output register may load
   logic         s1_valid_ff;
   logic         s1_valid_in;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;

   pix_type      pix [NumPix];
   pix_type      peak;
   lane_ctl_type lane_ctl;
   pix_type      lane_res [NumLanes];
   pix_type      pix0_ff;
   pix_type      pix1_ff;
   rsp_type      rsp_ff;

   // ---- register writes ----
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumLanes; i++) begin
            gain_ff[i] <= '0;
         end
         black_ff <= BlackReset;
         white_ff <= WhiteReset;
      end else if (csr_valid) begin
         unique case (csr_idx_type'(csr_index))
            CSR_GAIN_COL2:     gain_ff[0] <= csr_wdata[GainWidth-1:0];
            CSR_GAIN_COL3:     gain_ff[1] <= csr_wdata[GainWidth-1:0];
            CSR_GAIN_COL4:     gain_ff[2] <= csr_wdata[GainWidth-1:0];
            CSR_GAIN_COL5:     gain_ff[3] <= csr_wdata[GainWidth-1:0];
            CSR_GAIN_COL6:     gain_ff[4] <= csr_wdata[GainWidth-1:0];
            CSR_GAIN_COL7:     gain_ff[5] <= csr_wdata[GainWidth-1:0];
            CSR_BLACK_LEVEL:   black_ff   <= csr_wdata[PixWidth-1:0];
            CSR_NOMINAL_WHITE: white_ff   <= csr_wdata[PixWidth-1:0];
            default:           ;
         endcase
      end
   end

   // ---- handshake ----
   // output register frees when empty or taken; stage 1 drains into it
   assign out_adv   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !out_adv;
   assign req_xfer  = req_valid && !req_stall;
   assign scan_xfer = req_xfer && (mode_type'(req_data.mode) == MODE_SCAN);
   assign corr_xfer = req_xfer && (mode_type'(req_data.mode) == MODE_CORRECT);

   assign pix[0] = req_data.in_pix0;
   assign pix[1] = req_data.in_pix1;
   assign pix[2] = req_data.in_pix2;
   assign pix[3] = req_data.in_pix3;
   assign pix[4] = req_data.in_pix4;
   assign pix[5] = req_data.in_pix5;
   assign pix[6] = req_data.in_pix6;
   assign pix[7] = req_data.in_pix7;

   // ---- peak tracking, updated at the scan transfer ----
   csgc_peak u_peak (
      .clock         (clock),
      .reset         (reset),
      .scan          (scan_xfer),
      .frame_start   (req_data.frame_start),
      .nominal_white (white_ff),
      .pix           (pix),
      .peak          (peak)
   );

   // ---- correction lanes, pixels 2..7 ----
   assign lane_ctl.load   = corr_xfer;
   assign lane_ctl.bright = {1'b0, req_data.in_pix0} >
                            ({1'b0, black_ff} + (PixWidth+1)'(DarkMargin));
   assign lane_ctl.black  = black_ff;
   assign lane_ctl.peak   = peak;

   for (genvar g = 0; g < NumLanes; g++) begin : g_lane
      csgc_lane u_lane (
         .clock  (clock),
         .ctl    (lane_ctl),
         .pix    (pix[FirstLane + g]),
         .gain   (gain_ff[g]),
         .result (lane_res[g])
      );
   end

   // reference columns ride along with the lanes
   always_ff @(posedge clock) begin
      if (corr_xfer) begin
         pix0_ff <= req_data.in_pix0;
         pix1_ff <= req_data.in_pix1;
      end
   end

   // ---- merge into the output register ----
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (out_adv) begin
         s1_valid_in = 1'b0;
      end
      if (corr_xfer) begin
         s1_valid_in = 1'b1;
      end
      rsp_valid_in = out_adv ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv && s1_valid_ff) begin
         rsp_ff.out_pix0 <= pix0_ff;
         rsp_ff.out_pix1 <= pix1_ff;
         rsp_ff.out_pix2 <= lane_res[0];
         rsp_ff.out_pix3 <= lane_res[1];
         rsp_ff.out_pix4 <= lane_res[2];
         rsp_ff.out_pix5 <= lane_res[3];
         rsp_ff.out_pix6 <= lane_res[4];
         rsp_ff.out_pix7 <= lane_res[5];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---- checks ----
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff))
      else $error("input stalled with room in the pipeline");

   a_corr_enters_s1: assert property (@(posedge clock) disable iff (reset)
      corr_xfer |=> s1_valid_ff)
      else $error("correct block lost before the lanes");

   a_peak_monotonic: assert property (@(posedge clock) disable iff (reset)
      (scan_xfer && !req_data.frame_start) |=> (peak >= $past(peak)))
      else $error("peak dropped within a frame");

   a_peak_held: assert property (@(posedge clock) disable iff (reset)
      !scan_xfer |=> $stable(peak))
      else $error("peak changed without a scan transfer");

endmodule : column_stripe_gain_correction_unit
`default_nettype wire
